### design/ita2enc_pkg.sv
// Shared constants, types and code tables for the ITA2 shift encoder.
package ita2enc_pkg;

   localparam int CHAR_W = 8;
   localparam int CODE_W = 5;

   localparam logic [CODE_W-1:0] CODE_LTRS  = 5'd31;
   localparam logic [CODE_W-1:0] CODE_FIGS  = 5'd27;
   localparam logic [CODE_W-1:0] CODE_SPACE = 5'd4;
   localparam logic [CODE_W-1:0] CODE_LF    = 5'd2;
   localparam logic [CODE_W-1:0] CODE_CR    = 5'd8;

   localparam logic MODE_LETTERS = 1'b0;
   localparam logic MODE_FIGURES = 1'b1;

   // ITA2 letter codes, 'A' through 'Z'
   localparam logic [CODE_W-1:0] LETTER_CODES [0:25] = '{
      5'd3,  5'd25, 5'd14, 5'd9,  5'd1,  5'd13, 5'd26, 5'd20, 5'd6,
      5'd11, 5'd15, 5'd18, 5'd28, 5'd12, 5'd24, 5'd22, 5'd23, 5'd10,
      5'd5,  5'd16, 5'd7,  5'd30, 5'd19, 5'd29, 5'd21, 5'd17
   };

   // hit flag and code for one set
   typedef struct packed {
      logic              hit;
      logic [CODE_W-1:0] code;
   } set_code_type;

   // what the lookup decides for the word held in the input register
   typedef struct packed {
      logic              needs_shift;
      logic [CODE_W-1:0] shift_code;
      logic [CODE_W-1:0] main_code;
      logic              main_mode;
   } lookup_type;

   // mode tracking handed back from the emitter
   typedef struct packed {
      logic mode;
      logic phase;
   } mode_state_type;

   // letter set, character already upper-cased
   function automatic set_code_type letter_lookup(input logic [CHAR_W-1:0] up);
      set_code_type res;
      res.hit  = 1'b1;
      res.code = CODE_SPACE;
      if (up >= 8'h41 && up <= 8'h5A) begin
         res.code = LETTER_CODES[5'(up[4:0] - 5'd1)];
      end else begin
         case (up)
            8'h0A:   res.code = CODE_LF;
            8'h20:   res.code = CODE_SPACE;
            8'h0D:   res.code = CODE_CR;
            8'h09:   res.code = CODE_SPACE;   // tab sent as space
            default: res.hit  = 1'b0;
         endcase
      end
      return res;
   endfunction

   // figure set
   function automatic set_code_type figure_lookup(input logic [CHAR_W-1:0] ch);
      set_code_type res;
      res.hit = 1'b1;
      case (ch)
         8'h33:   res.code = 5'd1;    // 3
         8'h0A:   res.code = CODE_LF;
         8'h2D:   res.code = 5'd3;    // -
         8'h20:   res.code = CODE_SPACE;
         8'h27:   res.code = 5'd5;    // '
         8'h38:   res.code = 5'd6;    // 8
         8'h37:   res.code = 5'd7;    // 7
         8'h0D:   res.code = CODE_CR;
         8'h57:   res.code = 5'd9;    // W
         8'h34:   res.code = 5'd10;   // 4
         8'h07:   res.code = 5'd11;   // bell
         8'h2C:   res.code = 5'd12;   // ,
         8'h21:   res.code = 5'd13;   // !
         8'h3A:   res.code = 5'd14;   // :
         8'h28:   res.code = 5'd15;   // (
         8'h35:   res.code = 5'd16;   // 5
         8'h22:   res.code = 5'd17;   // "
         8'h29:   res.code = 5'd18;   // )
         8'h32:   res.code = 5'd19;   // 2
         8'h23:   res.code = 5'd20;   // #
         8'h36:   res.code = 5'd21;   // 6
         8'h30:   res.code = 5'd22;   // 0
         8'h31:   res.code = 5'd23;   // 1
         8'h39:   res.code = 5'd24;   // 9
         8'h3F:   res.code = 5'd25;   // ?
         8'h26:   res.code = 5'd26;   // &
         8'h2E:   res.code = 5'd28;   // .
         8'h2F:   res.code = 5'd29;   // /
         8'h3D:   res.code = 5'd30;   // =
         default: begin
            res.hit  = 1'b0;
            res.code = CODE_SPACE;
         end
      endcase
      return res;
   endfunction

endpackage

### design/ita2enc_if.sv
// Valid/ready channel interfaces for characters in and codes out.
interface ita2enc_req_if;
   logic                             valid;
   logic                             ready;
   logic [ita2enc_pkg::CHAR_W-1:0]   character;
   logic                             first;

   modport source (output valid, output character, output first, input ready);
   modport sink   (input valid, input character, input first, output ready);
endinterface

interface ita2enc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ita2enc_pkg::CODE_W-1:0]   code;
   logic                             is_shift;
   logic                             figures_mode;
   logic                             last;

   modport source (output valid, output code, output is_shift, output figures_mode,
                   output last, input ready);
   modport sink   (input valid, input code, input is_shift, input figures_mode,
                   input last, output ready);
endinterface

### design/ita2enc_lookup.sv
// Set lookup and shift decision for the character in the input register.
module ita2enc_lookup (
   input  logic [ita2enc_pkg::CHAR_W-1:0] character,
   input  logic                           first,
   input  ita2enc_pkg::mode_state_type    mode_state,
   output ita2enc_pkg::lookup_type        lookup
);

   logic [ita2enc_pkg::CHAR_W-1:0] up;
   ita2enc_pkg::set_code_type      lc;
   ita2enc_pkg::set_code_type      fc;
   logic                           eff_mode;

   // fold a-z to A-Z for the letter set only
   assign up = (character >= 8'h61 && character <= 8'h7A) ? character - 8'd32 : character;
   assign lc = ita2enc_pkg::letter_lookup(up);
   assign fc = ita2enc_pkg::figure_lookup(character);

   // first word of a message starts in letters; once its shift went out, keep the new mode
   assign eff_mode = (first && !mode_state.phase) ? ita2enc_pkg::MODE_LETTERS : mode_state.mode;

   always_comb begin
      lookup.needs_shift = 1'b0;
      lookup.shift_code  = ita2enc_pkg::CODE_LTRS;
      lookup.main_code   = ita2enc_pkg::CODE_SPACE;
      lookup.main_mode   = eff_mode;
      if (lc.hit && !fc.hit) begin
         lookup.needs_shift = (eff_mode != ita2enc_pkg::MODE_LETTERS);
         lookup.main_code   = lc.code;
         lookup.main_mode   = ita2enc_pkg::MODE_LETTERS;
      end else if (fc.hit && !lc.hit) begin
         lookup.needs_shift = (eff_mode != ita2enc_pkg::MODE_FIGURES);
         lookup.shift_code  = ita2enc_pkg::CODE_FIGS;
         lookup.main_code   = fc.code;
         lookup.main_mode   = ita2enc_pkg::MODE_FIGURES;
      end else if (lc.hit) begin
         lookup.main_code = eff_mode ? fc.code : lc.code;
      end
   end

endmodule

### design/ita2enc_emit.sv
// Output register, shift-word insertion and shift mode tracking.
module ita2enc_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  ita2enc_pkg::lookup_type     lookup,
   output ita2enc_pkg::mode_state_type mode_state,
   output logic                        item_done,
   ita2enc_rsp_if.source               rsp_ch
);

   logic                           mode_ff, mode_in;
   logic                           phase_ff, phase_in;
   logic                           valid_ff, valid_in;
   logic [ita2enc_pkg::CODE_W-1:0] code_ff, code_in;
   logic                           shift_ff, shift_in;
   logic                           fig_ff, fig_in;
   logic                           last_ff, last_in;
   logic                           load;

   assign load      = !valid_ff || rsp_ch.ready;
   assign item_done = item_valid && load && !lookup.needs_shift;

   assign mode_state.mode  = mode_ff;
   assign mode_state.phase = phase_ff;

   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      valid_in = valid_ff && !rsp_ch.ready;
      code_in  = code_ff;
      shift_in = shift_ff;
      fig_in   = fig_ff;
      last_in  = last_ff;
      if (item_valid && load) begin
         valid_in = 1'b1;
         mode_in  = lookup.main_mode;
         fig_in   = lookup.main_mode;
         if (lookup.needs_shift) begin
            code_in  = lookup.shift_code;
            shift_in = 1'b1;
            last_in  = 1'b0;
            phase_in = 1'b1;
         end else begin
            code_in  = lookup.main_code;
            shift_in = 1'b0;
            last_in  = 1'b1;
            phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ita2enc_pkg::MODE_LETTERS;
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
      code_ff  <= code_in;
      shift_ff <= shift_in;
      fig_ff   <= fig_in;
      last_ff  <= last_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.code         = code_ff;
   assign rsp_ch.is_shift     = shift_ff;
   assign rsp_ch.figures_mode = fig_ff;
   assign rsp_ch.last         = last_ff;

endmodule

### design/ita2_shift_encoder.sv
// Top level of the ITA2 shift encoder: input register, lookup and output register.
// Path: an accepted character waits in the input register; its code words go out from the output register.
// Throughput: 1 character per cycle while rsp is ready; a character that needs a LTRS/FIGS shift
//   occupies the output register for its shift word, then for its code.
// Reset: synchronous, active high; empties both registers, mode returns to letters.
module ita2_shift_encoder (
   input  logic          clock,
   input  logic          reset,
   ita2enc_req_if.sink   req_ch,
   ita2enc_rsp_if.source rsp_ch
);

   // input register: one character word waiting for the lookup
   logic                           item_valid_ff, item_valid_in;
   logic [ita2enc_pkg::CHAR_W-1:0] char_ff, char_in;
   logic                           first_ff, first_in;

   ita2enc_pkg::lookup_type        lookup;
   ita2enc_pkg::mode_state_type    mode_state;
   logic                           item_done;
   logic                           req_take;

   // a new word enters when the register is empty or its word is leaving now
   assign req_ch.ready = !item_valid_ff || item_done;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      item_valid_in = (item_valid_ff && !item_done) || req_take;
      char_in       = req_take ? req_ch.character : char_ff;
      first_in      = req_take ? req_ch.first     : first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      char_ff  <= char_in;
      first_ff <= first_in;
   end

   // set membership and shift decision against the current mode
   ita2enc_lookup u_lookup (
      .character  (char_ff),
      .first      (first_ff),
      .mode_state (mode_state),
      .lookup     (lookup)
   );

   // shift word goes out first and the character stays put until its code word is loaded
   ita2enc_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .lookup     (lookup),
      .mode_state (mode_state),
      .item_done  (item_done),
      .rsp_ch     (rsp_ch)
   );

endmodule

### design/ita2enc_checker.sv
// Port-level checks on the encoder output stream, bound to the top level.
module ita2enc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ita2enc_pkg::CODE_W-1:0] rsp_code,
   input logic                           rsp_is_shift,
   input logic                           rsp_figures_mode,
   input logic                           rsp_last
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // a shift word is never the last word of a character
   a_shift_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_shift |-> !rsp_last)
      else $error("shift word marked last");

   // shift code agrees with the mode it announces
   a_shift_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_shift |->
         (rsp_code == ita2enc_pkg::CODE_FIGS && rsp_figures_mode) ||
         (rsp_code == ita2enc_pkg::CODE_LTRS && !rsp_figures_mode))
      else $error("shift code and mode disagree");

   // the character's own code follows a taken shift word at once, in the new mode
   a_shift_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_is_shift |=>
         rsp_valid && !rsp_is_shift && rsp_last &&
         (rsp_figures_mode == $past(rsp_figures_mode)))
      else $error("code word did not follow shift word");

endmodule

bind ita2_shift_encoder ita2enc_checker u_ita2enc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_code         (rsp_ch.code),
   .rsp_is_shift     (rsp_ch.is_shift),
   .rsp_figures_mode (rsp_ch.figures_mode),
   .rsp_last         (rsp_ch.last)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ITA2 shift encoder: character stream in, code words out.
module tb_top;
   import ita2enc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;   // idle cycles with no word moving on either side
   localparam int DRAIN_CYCLES   = 10;     // settle time after the last code word
   localparam int RANDOM_CHARS   = 1400;

   localparam logic [CHAR_W-1:0] CHAR_BEL = 8'h07;
   localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;

   // ITA2 letter codes, A..Z
   localparam logic [CODE_W-1:0] ALPHA_CODE [0:25] = '{
      5'd3,  5'd25, 5'd14, 5'd9,  5'd1,  5'd13, 5'd26, 5'd20, 5'd6,
      5'd11, 5'd15, 5'd18, 5'd28, 5'd12, 5'd24, 5'd22, 5'd23, 5'd10,
      5'd5,  5'd16, 5'd7,  5'd30, 5'd19, 5'd29, 5'd21, 5'd17
   };

   // one character word queued for the driver; gap = idle cycles after it
   typedef struct {
      logic [CHAR_W-1:0] character;
      logic              first;
      int unsigned       gap;
   } char_word_t;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              is_shift;
      logic              figures_mode;
      logic              last;
   } code_word_t;

   logic clock;
   logic reset;

   ita2enc_req_if req_bus ();
   ita2enc_rsp_if rsp_bus ();

   ita2_shift_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   char_word_t  char_queue [$];     // characters waiting to be driven
   code_word_t  expected_codes [$]; // predicted code words, oldest first
   logic        shift_mode = MODE_LETTERS;
   logic        req_taken = 1'b0;
   int unsigned gap_left = 0;
   int unsigned rsp_hold = 0;
   int unsigned rsp_run = 0;
   int unsigned idle_cycles = 0;
   int unsigned chars_taken = 0;
   int unsigned chars_total = 0;
   int unsigned fault_count = 0;

   // figure characters that have no letter meaning (bell handled apart)
   string fig_chars = "3-'874,!:(5\")2#6019?&./=";

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // letter set; character already folded to upper case
   function automatic set_code_type alpha_entry(input logic [CHAR_W-1:0] up);
      set_code_type e;
      e.hit  = 1'b1;
      e.code = CODE_SPACE;
      if (up >= "A" && up <= "Z") begin
         e.code = ALPHA_CODE[int'(up) - int'("A")];
      end else begin
         case (up)
            CHAR_LF:  e.code = CODE_LF;
            CHAR_CR:  e.code = CODE_CR;
            " ":      e.code = CODE_SPACE;
            CHAR_TAB: e.code = CODE_SPACE;   // tab goes out as space
            default:  e.hit  = 1'b0;
         endcase
      end
      return e;
   endfunction

   function automatic set_code_type digit_entry(input logic [CHAR_W-1:0] ch);
      set_code_type e;
      e.hit  = 1'b1;
      e.code = CODE_SPACE;
      case (ch)
         "3":      e.code = 5'd1;
         CHAR_LF:  e.code = CODE_LF;
         "-":      e.code = 5'd3;
         " ":      e.code = CODE_SPACE;
         "'":      e.code = 5'd5;
         "8":      e.code = 5'd6;
         "7":      e.code = 5'd7;
         CHAR_CR:  e.code = CODE_CR;
         "W":      e.code = 5'd9;
         "4":      e.code = 5'd10;
         CHAR_BEL: e.code = 5'd11;
         ",":      e.code = 5'd12;
         "!":      e.code = 5'd13;
         ":":      e.code = 5'd14;
         "(":      e.code = 5'd15;
         "5":      e.code = 5'd16;
         "\"":     e.code = 5'd17;
         ")":      e.code = 5'd18;
         "2":      e.code = 5'd19;
         "#":      e.code = 5'd20;
         "6":      e.code = 5'd21;
         "0":      e.code = 5'd22;
         "1":      e.code = 5'd23;
         "9":      e.code = 5'd24;
         "?":      e.code = 5'd25;
         "&":      e.code = 5'd26;
         ".":      e.code = 5'd28;
         "/":      e.code = 5'd29;
         "=":      e.code = 5'd30;
         default:  e.hit  = 1'b0;
      endcase
      return e;
   endfunction

   // works out the code words for one accepted character, tracks the mode
   function automatic void encode_char(input logic [CHAR_W-1:0] ch, input logic first);
      logic [CHAR_W-1:0] up;
      set_code_type      ltr;
      set_code_type      fig;
      up  = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
      ltr = alpha_entry(up);
      fig = digit_entry(ch);
      if (first) shift_mode = MODE_LETTERS;
      if (ltr.hit && !fig.hit) begin
         if (shift_mode != MODE_LETTERS) begin
            shift_mode = MODE_LETTERS;
            expected_codes.push_back('{CODE_LTRS, 1'b1, MODE_LETTERS, 1'b0});
         end
         expected_codes.push_back('{ltr.code, 1'b0, MODE_LETTERS, 1'b1});
      end else if (fig.hit && !ltr.hit) begin
         if (shift_mode != MODE_FIGURES) begin
            shift_mode = MODE_FIGURES;
            expected_codes.push_back('{CODE_FIGS, 1'b1, MODE_FIGURES, 1'b0});
         end
         expected_codes.push_back('{fig.code, 1'b0, MODE_FIGURES, 1'b1});
      end else if (ltr.hit) begin
         // LF, CR, space, capital W: coded in the current mode, never a shift
         expected_codes.push_back('{(shift_mode == MODE_FIGURES) ? fig.code : ltr.code,
                                    1'b0, shift_mode, 1'b1});
      end else begin
         // unknown: space, mode unchanged
         expected_codes.push_back('{CODE_SPACE, 1'b0, shift_mode, 1'b1});
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // idle length: mostly none or short, a few long
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char();
      int unsigned r;
      int unsigned k;
      r = $urandom_range(0, 99);
      if (r < 28) return 8'("A" + $urandom_range(0, 25));
      if (r < 42) return 8'("a" + $urandom_range(0, 25));
      if (r < 72) begin
         k = $urandom_range(0, fig_chars.len());
         return (k == fig_chars.len()) ? CHAR_BEL : fig_chars[k];
      end
      if (r < 84) begin
         case ($urandom_range(0, 4))
            0:       return CHAR_LF;
            1:       return CHAR_CR;
            2:       return " ";
            3:       return CHAR_TAB;
            default: return "W";
         endcase
      end
      return 8'($urandom_range(0, 255));   // any byte, mostly unknown
   endfunction

   task automatic add_char(input logic [CHAR_W-1:0] ch, input logic first,
                           input int unsigned gap);
      char_word_t w;
      w.character = ch;
      w.first     = first;
      w.gap       = gap;
      char_queue.push_back(w);
   endtask

   // ------------------------------------------------------------------
   // Driver: request side, changes on the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      char_word_t w;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left != 0) begin
            req_bus.valid <= 1'b0;
            gap_left      <= gap_left - 1;
         end else if (char_queue.size() != 0) begin
            w = char_queue.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.character <= w.character;
            req_bus.first     <= w.first;
            gap_left          <= w.gap;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response side back-pressure: random stalls with occasional free-running stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= rsp_hold - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (rsp_run != 0) begin
            rsp_run <= rsp_run - 1;
         end else if ($urandom_range(0, 99) < 2) begin
            rsp_run <= $urandom_range(40, 150);
         end else if ($urandom_range(0, 99) < 35) begin
            rsp_hold <= idle_len();
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: both channels sampled on the rising edge, plus watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      code_word_t want;
      logic       req_fire;
      logic       rsp_fire;
      req_fire = req_bus.valid && req_bus.ready;
      rsp_fire = rsp_bus.valid && rsp_bus.ready;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_fire;
         if (req_fire) begin
            encode_char(req_bus.character, req_bus.first);
            chars_taken <= chars_taken + 1;
         end
         if (rsp_fire) begin
            if (expected_codes.size() == 0) begin
               $error("unexpected code word: code %0d is_shift %0b figures_mode %0b last %0b",
                      rsp_bus.code, rsp_bus.is_shift, rsp_bus.figures_mode, rsp_bus.last);
               fault_count++;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_bus.code !== want.code) begin
                  $error("code: expected %0d, got %0d", want.code, rsp_bus.code);
                  fault_count++;
               end
               if (rsp_bus.is_shift !== want.is_shift) begin
                  $error("is_shift: expected %0b, got %0b", want.is_shift, rsp_bus.is_shift);
                  fault_count++;
               end
               if (rsp_bus.figures_mode !== want.figures_mode) begin
                  $error("figures_mode: expected %0b, got %0b",
                         want.figures_mode, rsp_bus.figures_mode);
                  fault_count++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_bus.last);
                  fault_count++;
               end
            end
         end
         if (req_fire || rsp_fire) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ita2_shift_encoder: mismatch");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------
   initial begin
      int unsigned n;
      int unsigned len;
      logic        dense;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.character = '0;
      req_bus.first     = 1'b0;
      rsp_bus.ready     = 1'b0;

      // directed: shifts both ways, both-set chars in each mode, unknowns, first
      add_char("A", 1'b1, 0);        // letters from reset, no shift
      add_char("z", 1'b0, 0);        // lower case folds
      add_char("3", 1'b0, 1);        // FIGS then 1
      add_char("W", 1'b0, 0);        // capital W in figures mode: 9
      add_char(CHAR_BEL, 1'b0, 2);
      add_char("$", 1'b0, 0);        // dollar: unknown, stays in figures
      add_char(8'hFF, 1'b0, 0);
      add_char("w", 1'b0, 0);        // lower w is letters only: LTRS then 19
      add_char("W", 1'b0, 0);        // capital W in letters mode: 19
      add_char(CHAR_LF, 1'b0, 0);
      add_char(CHAR_CR, 1'b0, 3);
      add_char(" ", 1'b0, 0);
      add_char(8'h00, 1'b0, 0);
      add_char(8'hC9, 1'b0, 0);      // Latin-1 letter: unknown
      add_char("=", 1'b0, 0);
      add_char(CHAR_TAB, 1'b0, 0);   // tab from figures: LTRS then space
      add_char(".", 1'b0, 0);
      add_char(".", 1'b1, 0);        // first clears figures, shift again
      add_char("A", 1'b1, 5);        // first in figures mode: no shift needed
      add_char("?", 1'b0, 0);
      add_char(CHAR_LF, 1'b0, 0);    // LF in figures mode
      add_char("Q", 1'b1, 0);
      add_char(8'h7F, 1'b0, 0);
      add_char("0", 1'b0, 0);

      // random messages; some packed back to back
      n = 0;
      while (n < RANDOM_CHARS) begin
         len   = $urandom_range(1, 24);
         dense = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < len; i++) begin
            add_char(pick_char(), (i == 0) || ($urandom_range(0, 39) == 0),
                     dense ? 0 : idle_len());
         end
         n += len;
      end
      chars_total = char_queue.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (chars_taken != chars_total || expected_codes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fault_count == 0) begin
         $display("ita2_shift_encoder: match");
      end else begin
         $display("ita2_shift_encoder: mismatch");
      end
      $finish;
   end

endmodule

### sim.f
design/ita2enc_pkg.sv
design/ita2enc_if.sv
design/ita2enc_lookup.sv
design/ita2enc_emit.sv
design/ita2_shift_encoder.sv
design/ita2enc_checker.sv
tb/tb_top.sv
